>>> hw/rtl/htm_pkg.sv
// Package for the mesh index unit: types, constants and root-triangle helpers.
package htm_pkg;

    localparam int FRAC_BITS = 30;
    localparam int MAX_LEVEL = 13;
    localparam int INDEX_W   = 30;
    localparam int COORD_W   = 32;
    localparam int SUM_W     = 33;
    localparam int CROSS_W   = 35;
    localparam int OPND_W    = 36;
    localparam int ACC_W     = 72;
    localparam int RAD_W     = 66;
    localparam int ROOT_W    = 33;
    localparam int REM_W     = 34;
    localparam int QUO_W     = 32;
    localparam int DVD_W     = 64;
    localparam int ROOT_OFFSET = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec;

    typedef enum logic [3:0] {
        S_IDLE, S_LEVEL, S_SUM, S_SQ_MUL, S_SQ_ACC, S_RT_INIT, S_RT, S_DV_SET,
        S_DV, S_DV_STORE, S_X_MUL, S_X_ACC, S_D_MUL, S_D_ACC, S_DECIDE, S_DONE
    } t_state;

    // Which edge midpoint is being formed: sv0 from (v1,v2), sv1 from (v2,v0), sv2 from (v0,v1).
    typedef enum logic [1:0] {MID_SV0, MID_SV1, MID_SV2} t_mid;

    // Child number; CH_0 to CH_2 also name the side test that selects them.
    typedef enum logic [1:0] {CH_0, CH_1, CH_2, CH_3} t_child;

    // Vertex codes: +X, +Y, +Z, -X, -Y, -Z.
    typedef enum logic [2:0] {PX, PY, PZ, NX, NY, NZ} t_vcode;

    function automatic logic [2:0] pick_root(logic signed [COORD_W-1:0] x,
                                             logic signed [COORD_W-1:0] y,
                                             logic signed [COORD_W-1:0] z);
        logic north;
        logic [2:0] r;
        north = (z >= 0);
        if (y > 0) begin
            if (north) r = (x > 0) ? 3'd7 : 3'd6;
            else       r = (x > 0) ? 3'd0 : 3'd1;
        end else if (y == 0) begin
            if (north) r = (x >= 0) ? 3'd7 : 3'd5;
            else       r = (x >= 0) ? 3'd0 : 3'd2;
        end else begin
            if (north) r = (x < 0) ? 3'd5 : 3'd4;
            else       r = (x < 0) ? 3'd2 : 3'd3;
        end
        return r;
    endfunction

    function automatic t_vcode root_corner(logic [2:0] root, logic [1:0] c);
        t_vcode a, b, d;
        case (root)
            3'd0: begin a = PX; b = NZ; d = PY; end
            3'd1: begin a = PY; b = NZ; d = NX; end
            3'd2: begin a = NX; b = NZ; d = NY; end
            3'd3: begin a = NY; b = NZ; d = PX; end
            3'd4: begin a = PX; b = PZ; d = NY; end
            3'd5: begin a = NY; b = PZ; d = NX; end
            3'd6: begin a = NX; b = PZ; d = PY; end
            default: begin a = PY; b = PZ; d = PX; end
        endcase
        case (c)
            2'd0:    return a;
            2'd1:    return b;
            default: return d;
        endcase
    endfunction

    function automatic t_vec corner_vec(t_vcode code);
        t_vec v;
        logic signed [COORD_W-1:0] one;
        one = COORD_W'(1) <<< FRAC_BITS;
        v = '0;
        case (code)
            PX: v.x = one;
            PY: v.y = one;
            PZ: v.z = one;
            NX: v.x = -one;
            NY: v.y = -one;
            NZ: v.z = -one;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] vcomp(t_vec v, logic [1:0] i);
        case (i)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic t_vec set_comp(t_vec v, logic [1:0] i,
                                      logic signed [COORD_W-1:0] val);
        t_vec r;
        r = v;
        case (i)
            2'd0:    r.x = val;
            2'd1:    r.y = val;
            default: r.z = val;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/htm_index_of_vector.sv
// Mesh index unit: maps a direction vector to its triangular-mesh trixel index.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one vector per transaction,
//   components signed fixed point with 30 fraction bits; only direction matters.
//   Output channel (o_out_valid / i_out_ready) returns one 30-bit mesh index per
//   input: root number plus 8, then two child bits per subdivision level.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the subdivision level;
//   values above 13 act as 13. Write it only while the unit is idle.
// Timing:
//   One vector at a time; o_in_ready is high only while idle. All arithmetic
//   runs through one shared 36x36 multiplier, one bit-serial square root
//   (33 steps) and one bit-serial divider (32 steps). A level needs two or three
//   midpoints and one to three tests.
// Reset: synchronous, active low; clears the sequencer, the output valid and
//   the level register (level 0).
// Stall: a finished index waits in the output register; the next vector is
//   accepted meanwhile, and its result holds until the previous one is taken.
module htm_index_of_vector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [29:0] o_mesh_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_subdivision_level
);

    localparam int ACC_W  = htm_pkg::ACC_W;
    localparam int RAD_W  = htm_pkg::RAD_W;
    localparam int ROOT_W = htm_pkg::ROOT_W;
    localparam int REM_W  = htm_pkg::REM_W;
    localparam int QUO_W  = htm_pkg::QUO_W;
    localparam int DVD_W  = htm_pkg::DVD_W;
    localparam int SUM_W  = htm_pkg::SUM_W;
    localparam int CW     = htm_pkg::COORD_W;
    localparam int XW     = htm_pkg::CROSS_W;
    localparam int OW     = htm_pkg::OPND_W;
    localparam int IW     = htm_pkg::INDEX_W;

    // Control state
    htm_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic [3:0]      r_cfg_level;

    // Datapath state
    htm_pkg::t_vec   r_vin, n_vin;
    htm_pkg::t_vec   r_v0, n_v0, r_v1, n_v1, r_v2, n_v2;
    htm_pkg::t_vec   r_sv0, n_sv0, r_sv1, n_sv1, r_sv2, n_sv2;
    logic [2:0][SUM_W-1:0] r_s, n_s;
    logic [2:0][XW-1:0]    r_c, n_c;
    logic signed [ACC_W-1:0] r_acc, n_acc, r_prod;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [ROOT_W-1:0] r_drem, n_drem;
    logic [QUO_W-1:0]  r_dlo, n_dlo, r_q, n_q;
    logic [5:0]        r_k, n_k;
    logic [1:0]        r_comp, n_comp;
    logic              r_term, n_term;
    htm_pkg::t_mid     r_sel, n_sel;
    htm_pkg::t_child   r_test, n_test;
    logic [IW-1:0]     r_index, n_index, r_mesh, n_mesh;
    logic [3:0]        r_levels, n_levels;

    // Shared multiplier operands
    logic signed [OW-1:0] mul_a, mul_b;

    // Operand selection
    htm_pkg::t_vec mid_a, mid_b, sd_p, sd_q;
    logic [1:0]    ci_j, ci_k;
    logic [2:0]    root_no;
    logic [REM_W+1:0]  rt_sh, rt_trial;
    logic [ROOT_W:0]   dv_t, dv_div;
    logic [SUM_W-1:0]  mag;
    logic [DVD_W-1:0]  dvd;
    logic signed [ACC_W-1:0] xdiff;
    logic signed [CW-1:0]    qval;
    logic signed [SUM_W-1:0] s_cur;

    assign o_in_ready   = (r_state == htm_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_mesh_index = r_mesh;

    always_comb begin
        case (r_sel)
            htm_pkg::MID_SV0: begin mid_a = r_v1; mid_b = r_v2; end
            htm_pkg::MID_SV1: begin mid_a = r_v2; mid_b = r_v0; end
            default:          begin mid_a = r_v0; mid_b = r_v1; end
        endcase
        case (r_test)
            htm_pkg::CH_0: begin sd_p = r_sv2; sd_q = r_sv1; end
            htm_pkg::CH_1: begin sd_p = r_sv0; sd_q = r_sv2; end
            default:       begin sd_p = r_sv1; sd_q = r_sv0; end
        endcase
        case (r_comp)
            2'd0:    begin ci_j = 2'd1; ci_k = 2'd2; end
            2'd1:    begin ci_j = 2'd2; ci_k = 2'd0; end
            default: begin ci_j = 2'd0; ci_k = 2'd1; end
        endcase
    end

    // Shared multiplier with registered product
    always_comb begin
        s_cur = $signed(r_s[r_comp]);
        case (r_state)
            htm_pkg::S_SQ_MUL: begin
                mul_a = OW'(s_cur);
                mul_b = OW'(s_cur);
            end
            htm_pkg::S_X_MUL: begin
                if (!r_term) begin
                    mul_a = OW'(htm_pkg::vcomp(sd_p, ci_j));
                    mul_b = OW'(htm_pkg::vcomp(sd_q, ci_k));
                end else begin
                    mul_a = OW'(htm_pkg::vcomp(sd_p, ci_k));
                    mul_b = OW'(htm_pkg::vcomp(sd_q, ci_j));
                end
            end
            default: begin
                mul_a = OW'(htm_pkg::vcomp(r_vin, r_comp));
                mul_b = OW'($signed(r_c[r_comp]));
            end
        endcase
    end

    always_comb begin
        // Square root step: bring down two radicand bits, try (root<<2)|1
        rt_sh    = {r_rem, r_rad[RAD_W-1 -: 2]};
        rt_trial = {1'b0, r_root, 2'b01};
        // Divider step: bring down one dividend bit, try the root
        dv_t     = {r_drem, r_dlo[QUO_W-1]};
        dv_div   = {1'b0, r_root};
        mag      = s_cur[SUM_W-1] ? SUM_W'(-s_cur) : SUM_W'(s_cur);
        dvd      = (DVD_W'(mag) << htm_pkg::FRAC_BITS) + DVD_W'(r_root >> 1);
        xdiff    = (r_acc - r_prod) >>> htm_pkg::FRAC_BITS;
        qval     = s_cur[SUM_W-1] ? -$signed(r_q) : $signed(r_q);
        root_no  = htm_pkg::pick_root(i_vec_x, i_vec_y, i_vec_z);
    end

    always_comb begin
        n_state = r_state;  n_out_valid = r_out_valid & ~i_out_ready;
        n_vin = r_vin;  n_v0 = r_v0;  n_v1 = r_v1;  n_v2 = r_v2;
        n_sv0 = r_sv0;  n_sv1 = r_sv1;  n_sv2 = r_sv2;
        n_s = r_s;  n_c = r_c;  n_acc = r_acc;  n_rad = r_rad;  n_rem = r_rem;
        n_root = r_root;  n_drem = r_drem;  n_dlo = r_dlo;  n_q = r_q;
        n_k = r_k;  n_comp = r_comp;  n_term = r_term;  n_sel = r_sel;
        n_test = r_test;  n_index = r_index;  n_mesh = r_mesh;  n_levels = r_levels;

        case (r_state)
            htm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_vin = '{x: i_vec_x, y: i_vec_y, z: i_vec_z};
                    n_v0 = htm_pkg::corner_vec(htm_pkg::root_corner(root_no, 2'd0));
                    n_v1 = htm_pkg::corner_vec(htm_pkg::root_corner(root_no, 2'd1));
                    n_v2 = htm_pkg::corner_vec(htm_pkg::root_corner(root_no, 2'd2));
                    n_index = IW'(root_no) + IW'(htm_pkg::ROOT_OFFSET);
                    n_levels = (r_cfg_level > 4'(htm_pkg::MAX_LEVEL)) ?
                               4'(htm_pkg::MAX_LEVEL) : r_cfg_level;
                    n_state = htm_pkg::S_LEVEL;
                end
            end
            htm_pkg::S_LEVEL: begin
                if (r_levels == '0) begin
                    n_state = htm_pkg::S_DONE;
                end else begin
                    n_sel = htm_pkg::MID_SV1;
                    n_state = htm_pkg::S_SUM;
                end
            end
            htm_pkg::S_SUM: begin
                n_s[0] = SUM_W'(mid_a.x) + SUM_W'(mid_b.x);
                n_s[1] = SUM_W'(mid_a.y) + SUM_W'(mid_b.y);
                n_s[2] = SUM_W'(mid_a.z) + SUM_W'(mid_b.z);
                n_acc = '0;
                n_comp = 2'd0;
                n_state = htm_pkg::S_SQ_MUL;
            end
            htm_pkg::S_SQ_MUL: n_state = htm_pkg::S_SQ_ACC;
            htm_pkg::S_SQ_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_comp == 2'd2) begin
                    n_state = htm_pkg::S_RT_INIT;
                end else begin
                    n_comp = r_comp + 2'd1;
                    n_state = htm_pkg::S_SQ_MUL;
                end
            end
            htm_pkg::S_RT_INIT: begin
                n_rad = r_acc[RAD_W-1:0];
                n_rem = '0;
                n_root = '0;
                n_k = 6'(ROOT_W - 1);
                n_state = htm_pkg::S_RT;
            end
            htm_pkg::S_RT: begin
                if (rt_sh >= rt_trial) begin
                    n_rem = REM_W'(rt_sh - rt_trial);
                    n_root = {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem = REM_W'(rt_sh);
                    n_root = {r_root[ROOT_W-2:0], 1'b0};
                end
                n_rad = r_rad << 2;
                if (r_k == '0) begin
                    n_comp = 2'd0;
                    n_state = htm_pkg::S_DV_SET;
                end else begin
                    n_k = r_k - 6'd1;
                end
            end
            htm_pkg::S_DV_SET: begin
                n_q = '0;
                if (r_root == '0) begin
                    // Degenerate midpoint: every component is zero
                    n_state = htm_pkg::S_DV_STORE;
                end else begin
                    n_drem = ROOT_W'(dvd[DVD_W-1:QUO_W]);
                    n_dlo = dvd[QUO_W-1:0];
                    n_k = 6'(QUO_W - 1);
                    n_state = htm_pkg::S_DV;
                end
            end
            htm_pkg::S_DV: begin
                if (dv_t >= dv_div) begin
                    n_drem = ROOT_W'(dv_t - dv_div);
                    n_q = {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_drem = ROOT_W'(dv_t);
                    n_q = {r_q[QUO_W-2:0], 1'b0};
                end
                n_dlo = r_dlo << 1;
                if (r_k == '0) n_state = htm_pkg::S_DV_STORE;
                else           n_k = r_k - 6'd1;
            end
            htm_pkg::S_DV_STORE: begin
                case (r_sel)
                    htm_pkg::MID_SV0: n_sv0 = htm_pkg::set_comp(r_sv0, r_comp, qval);
                    htm_pkg::MID_SV1: n_sv1 = htm_pkg::set_comp(r_sv1, r_comp, qval);
                    default:          n_sv2 = htm_pkg::set_comp(r_sv2, r_comp, qval);
                endcase
                if (r_comp != 2'd2) begin
                    n_comp = r_comp + 2'd1;
                    n_state = htm_pkg::S_DV_SET;
                end else begin
                    n_comp = 2'd0;
                    n_term = 1'b0;
                    case (r_sel)
                        htm_pkg::MID_SV1: begin
                            n_sel = htm_pkg::MID_SV2;
                            n_state = htm_pkg::S_SUM;
                        end
                        htm_pkg::MID_SV2: begin
                            n_test = htm_pkg::CH_0;
                            n_state = htm_pkg::S_X_MUL;
                        end
                        default: begin
                            n_test = htm_pkg::CH_1;
                            n_state = htm_pkg::S_X_MUL;
                        end
                    endcase
                end
            end
            htm_pkg::S_X_MUL: n_state = htm_pkg::S_X_ACC;
            htm_pkg::S_X_ACC: begin
                if (!r_term) begin
                    n_acc = r_prod;
                    n_term = 1'b1;
                    n_state = htm_pkg::S_X_MUL;
                end else begin
                    n_c[r_comp] = xdiff[XW-1:0];
                    n_term = 1'b0;
                    if (r_comp == 2'd2) begin
                        n_comp = 2'd0;
                        n_acc = '0;
                        n_state = htm_pkg::S_D_MUL;
                    end else begin
                        n_comp = r_comp + 2'd1;
                        n_state = htm_pkg::S_X_MUL;
                    end
                end
            end
            htm_pkg::S_D_MUL: n_state = htm_pkg::S_D_ACC;
            htm_pkg::S_D_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_comp == 2'd2) begin
                    n_state = htm_pkg::S_DECIDE;
                end else begin
                    n_comp = r_comp + 2'd1;
                    n_state = htm_pkg::S_D_MUL;
                end
            end
            htm_pkg::S_DECIDE: begin
                n_comp = 2'd0;
                n_term = 1'b0;
                if (!r_acc[ACC_W-1] || r_test == htm_pkg::CH_2) begin
                    // Keep the child; a failed third test leaves the center child
                    case (r_acc[ACC_W-1] ? htm_pkg::CH_3 : r_test)
                        htm_pkg::CH_0: begin n_v1 = r_sv2; n_v2 = r_sv1; end
                        htm_pkg::CH_1: begin n_v0 = r_v1; n_v1 = r_sv0; n_v2 = r_sv2; end
                        htm_pkg::CH_2: begin n_v0 = r_v2; n_v1 = r_sv1; n_v2 = r_sv0; end
                        default:       begin n_v0 = r_sv0; n_v1 = r_sv1; n_v2 = r_sv2; end
                    endcase
                    n_index = {r_index[IW-3:0],
                               r_acc[ACC_W-1] ? 2'(htm_pkg::CH_3) : 2'(r_test)};
                    n_levels = r_levels - 4'd1;
                    n_state = htm_pkg::S_LEVEL;
                end else if (r_test == htm_pkg::CH_0) begin
                    n_sel = htm_pkg::MID_SV0;
                    n_state = htm_pkg::S_SUM;
                end else begin
                    n_test = htm_pkg::CH_2;
                    n_state = htm_pkg::S_X_MUL;
                end
            end
            htm_pkg::S_DONE: begin
                // Hold the result until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    n_mesh = r_index;
                    n_out_valid = 1'b1;
                    n_state = htm_pkg::S_IDLE;
                end
            end
            default: n_state = htm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_level <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) r_cfg_level <= i_cfg_subdivision_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_vin <= n_vin;  r_v0 <= n_v0;  r_v1 <= n_v1;  r_v2 <= n_v2;
        r_sv0 <= n_sv0;  r_sv1 <= n_sv1;  r_sv2 <= n_sv2;
        r_s <= n_s;  r_c <= n_c;  r_acc <= n_acc;  r_rad <= n_rad;  r_rem <= n_rem;
        r_root <= n_root;  r_drem <= n_drem;  r_dlo <= n_dlo;  r_q <= n_q;
        r_k <= n_k;  r_comp <= n_comp;  r_term <= n_term;  r_sel <= n_sel;
        r_test <= n_test;  r_index <= n_index;  r_mesh <= n_mesh;  r_levels <= n_levels;
    end

    // Level count never exceeds the saturation limit while busy
    a_levels_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != htm_pkg::S_IDLE) |-> (r_levels <= 4'(htm_pkg::MAX_LEVEL)))
        else $error("level count above limit");

    // Divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htm_pkg::S_DV) |-> (r_root != '0))
        else $error("divide by zero root");

    // Partial remainder stays below the divisor, so 32 quotient bits suffice
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htm_pkg::S_DV) |-> (r_drem < r_root))
        else $error("divider remainder overflow");

    // An accepted vector always starts the level loop
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == htm_pkg::S_LEVEL))
        else $error("accepted vector did not start");

endmodule
